>>> hw/rtl/bwg_pkg.sv
`default_nettype none
package bwg_pkg;

   // Fixed-point format of positions, registers, distances and gradients
   localparam int FRAC_BITS = 16;

   // Spline breakpoints in FRAC_BITS fraction
   localparam logic [17:0] HALF          = 18'd32768;
   localparam logic [17:0] THREE_HALF    = 18'd98304;
   localparam logic [17:0] LIM           = 18'd131072;
   localparam logic [15:0] THREE_QUARTER = 16'd49152;

   // Register indexes on the configuration port
   localparam logic CSR_CELL_SIZE     = 1'b0;
   localparam logic CSR_INV_CELL_SIZE = 1'b1;

   localparam logic [31:0] REG_RESET = 32'd65536;

   // Saturation limits of the gradient outputs
   localparam logic [32:0] POS_MAX = 33'h0_7FFF_FFFF;
   localparam logic [32:0] NEG_MAX = 33'h0_8000_0000;

   typedef struct packed {
      logic [9:0]         node_i;
      logic [9:0]         node_j;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } bwg_req_type;

   typedef struct packed {
      logic [15:0]        weight;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
   } bwg_rsp_type;

   // Per-axis spline result: weight, slope magnitude, slope sign
   typedef struct packed {
      logic [15:0] w;
      logic [16:0] sm;
      logic        sneg;
   } bwg_axis_type;

endpackage
`default_nettype wire

>>> hw/rtl/bspline_weight_gradient.sv
`default_nettype none
// Quadratic B-spline weight and gradient for one grid node and one particle.
// A request is taken whenever start is high; busy never rises, so one request
// can enter on every clock. The result appears on rsp_data with rsp_valid high
// for exactly one cycle, in request order; the receiver cannot stall, so it
// must take every strobe. The datapath has nine register stages: node offset,
// distance, reciprocal scale, clamp, square, spline, cross products, gradient
// scale and saturation. cell_size and inv_cell_size are written through the
// csr_ port, which is always ready; write them only while no request is in
// flight.
module bspline_weight_gradient
   import bwg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire bwg_req_type req_data,
   output logic             rsp_valid,
   output bwg_rsp_type      rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic [31:0]  cell_size_ff;
   logic [31:0]  inv_cell_size_ff;
   logic         accept;
   logic         vx;
   logic         vy;
   bwg_axis_type ax;
   bwg_axis_type ay;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff     <= REG_RESET;
         inv_cell_size_ff <= REG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CELL_SIZE:     cell_size_ff     <= csr_wdata;
            CSR_INV_CELL_SIZE: inv_cell_size_ff <= csr_wdata;
            default:           cell_size_ff     <= cell_size_ff;
         endcase
      end
   end

   bwg_axis u_axis_x (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .node          (req_data.node_i),
      .pos           (req_data.pos_x),
      .cell_size     (cell_size_ff),
      .inv_cell_size (inv_cell_size_ff),
      .out_valid     (vx),
      .out_data      (ax)
   );

   bwg_axis u_axis_y (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .node          (req_data.node_j),
      .pos           (req_data.pos_y),
      .cell_size     (cell_size_ff),
      .inv_cell_size (inv_cell_size_ff),
      .out_valid     (vy),
      .out_data      (ay)
   );

   bwg_combine u_combine (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (vx && vy),
      .ax            (ax),
      .ay            (ay),
      .inv_cell_size (inv_cell_size_ff),
      .out_valid     (rsp_valid),
      .out_data      (rsp_data)
   );

endmodule
`default_nettype wire

>>> hw/rtl/bwg_axis.sv
`default_nettype none
module bwg_axis
   import bwg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [9:0]         node,
   input  wire logic signed [31:0] pos,
   input  wire logic [31:0]        cell_size,
   input  wire logic [31:0]        inv_cell_size,
   output logic                    out_valid,
   output bwg_axis_type            out_data
);

   logic [5:0] valid_ff;

   // Stage A: node offset
   logic [41:0]        prod_ff;
   logic signed [31:0] pos_ff;

   // Stage B: distance magnitude
   logic [43:0] diff;
   logic [43:0] mag_in;
   logic [10:0] hi_ff;
   logic [31:0] lo_ff;
   logic        neg_b_ff;

   // Stage C: scale by reciprocal
   logic [42:0] t_in;
   logic [63:0] plo_in;
   logic [42:0] t_ff;
   logic [47:0] plo_ff;
   logic        neg_c_ff;

   // Stage D: clamp
   logic [17:0] a_in;
   logic [17:0] a_ff;
   logic        neg_d_ff;

   // Stage E: square
   logic        zero_in;
   logic        inner_in;
   logic [17:0] e;
   logic [16:0] x_in;
   logic [33:0] sq_ff;
   logic [16:0] x_ff;
   logic        zero_ff;
   logic        inner_ff;
   logic        neg_e_ff;

   // Stage F: weight and slope
   bwg_axis_type res_in;
   bwg_axis_type res_ff;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 42'(node) * 42'(cell_size);
      pos_ff  <= pos;
   end

   // Signed distance, then magnitude split into high and low words
   assign diff   = {{12{pos_ff[31]}}, pos_ff} - {2'b00, prod_ff};
   assign mag_in = diff[43] ? (~diff + 44'd1) : diff;

   always_ff @(posedge clock) begin
      hi_ff    <= mag_in[42:32];
      lo_ff    <= mag_in[31:0];
      neg_b_ff <= diff[43];
   end

   assign t_in   = 43'(hi_ff) * 43'(inv_cell_size);
   assign plo_in = 64'(lo_ff) * 64'(inv_cell_size);

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      plo_ff   <= plo_in[63:FRAC_BITS];
      neg_c_ff <= neg_b_ff;
   end

   // Clamp normalized distance to 2.0
   always_comb begin
      logic [48:0] full;
      full = {31'd0, t_ff[1:0], 16'd0} + {1'b0, plo_ff};
      if (t_ff > 43'd2 || full > {31'd0, LIM}) begin
         a_in = LIM;
      end else begin
         a_in = full[17:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      neg_d_ff <= neg_c_ff;
   end

   // Pick the square operand by spline region
   assign zero_in  = a_ff >= THREE_HALF;
   assign inner_in = a_ff < HALF;
   assign e        = THREE_HALF - a_ff;
   assign x_in     = inner_in ? a_ff[16:0] : e[16:0];

   always_ff @(posedge clock) begin
      sq_ff    <= 34'(x_in) * 34'(x_in);
      x_ff     <= x_in;
      zero_ff  <= zero_in;
      inner_ff <= inner_in;
      neg_e_ff <= neg_d_ff;
   end

   // Weight and slope per region
   always_comb begin
      if (zero_ff) begin
         res_in.w  = '0;
         res_in.sm = '0;
      end else if (inner_ff) begin
         res_in.w  = THREE_QUARTER - sq_ff[31:16];
         res_in.sm = {x_ff[15:0], 1'b0};
      end else begin
         res_in.w  = sq_ff[32:17];
         res_in.sm = x_ff;
      end
      res_in.sneg = !neg_e_ff && (res_in.sm != 17'd0);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid = valid_ff[5];
   assign out_data  = res_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bwg_combine.sv
`default_nettype none
module bwg_combine
   import bwg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire bwg_axis_type ax,
   input  wire bwg_axis_type ay,
   input  wire logic [31:0]  inv_cell_size,
   output logic              out_valid,
   output bwg_rsp_type       out_data
);

   logic [2:0] valid_ff;

   // Stage G: cross products
   logic [31:0] wp_in;
   logic [32:0] gx_in;
   logic [32:0] gy_in;
   logic [15:0] weight_g_ff;
   logic [16:0] gx_ff;
   logic [16:0] gy_ff;
   logic        snx_g_ff;
   logic        sny_g_ff;

   // Stage H: scale by reciprocal
   logic [48:0] mx_in;
   logic [48:0] my_in;
   logic [32:0] mx_ff;
   logic [32:0] my_ff;
   logic [15:0] weight_h_ff;
   logic        snx_h_ff;
   logic        sny_h_ff;

   // Stage I: saturate and present
   bwg_rsp_type rsp_in;
   bwg_rsp_type rsp_ff;

   function automatic logic [31:0] sat(input logic [32:0] m, input logic sneg);
      logic [32:0] c;
      if (sneg) begin
         c = (m > NEG_MAX) ? NEG_MAX : m;
         sat = 32'(33'd0 - c);
      end else begin
         c = (m > POS_MAX) ? POS_MAX : m;
         sat = c[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign wp_in = 32'(ax.w) * 32'(ay.w);
   assign gx_in = 33'(ax.sm) * 33'(ay.w);
   assign gy_in = 33'(ay.sm) * 33'(ax.w);

   always_ff @(posedge clock) begin
      weight_g_ff <= wp_in[31:16];
      gx_ff       <= gx_in[32:FRAC_BITS];
      gy_ff       <= gy_in[32:FRAC_BITS];
      snx_g_ff    <= ax.sneg;
      sny_g_ff    <= ay.sneg;
   end

   assign mx_in = 49'(gx_ff) * 49'(inv_cell_size);
   assign my_in = 49'(gy_ff) * 49'(inv_cell_size);

   always_ff @(posedge clock) begin
      mx_ff       <= mx_in[48:FRAC_BITS];
      my_ff       <= my_in[48:FRAC_BITS];
      weight_h_ff <= weight_g_ff;
      snx_h_ff    <= snx_g_ff;
      sny_h_ff    <= sny_g_ff;
   end

   always_comb begin
      rsp_in.weight = weight_h_ff;
      rsp_in.grad_x = sat(mx_ff, snx_h_ff);
      rsp_in.grad_y = sat(my_ff, sny_h_ff);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff[2];
   assign out_data  = rsp_ff;

endmodule
`default_nettype wire
